[src/fir_pkg.sv]
// ----------------------------------------------------------------------------
// fir_pkg
// Shared types and constants for the Q31 FIR filter: sizes of the tap stores,
// request kinds and the control bundle of the multiply-accumulate unit.
// ----------------------------------------------------------------------------
package fir_pkg;

    // Built maximum number of taps (depth of the delay line and coefficient store)
    localparam int MAX_TAPS = 32;
    localparam int TAP_W    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;

    // Field widths
    localparam int SAMPLE_W      = 32;
    localparam int COEFF_IDX_W   = 5;
    localparam int TAP_COUNT_W   = 6;
    localparam int ACC_W         = 64;
    localparam int Q31_SHIFT     = 31;
    localparam int S_TDATA_W     = 72;
    localparam int M_TDATA_W     = 32;

    localparam logic [TAP_COUNT_W-1:0] TAP_COUNT_RESET = TAP_COUNT_W'(32);

    // Request kinds carried on s_tuser
    localparam logic REQ_FILTER = 1'b0;
    localparam logic REQ_COEFF  = 1'b1;

    // Control to the shared multiply-accumulate unit
    typedef struct packed {
        logic clear;     // zero the accumulator
        logic op_valid;  // operands valid this cycle
    } mac_ctrl_t;

endpackage

[src/fir_ram.sv]
// ----------------------------------------------------------------------------
// fir_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fir_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                          aclk,
    input  logic                                          we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                              wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                              rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[src/fir_mac.sv]
// ----------------------------------------------------------------------------
// fir_mac
// Shared Q31 multiply-accumulate unit: a registered 32x32 signed product
// feeding a wrapping 64-bit accumulator. Result is accumulator bits 62..31.
// ----------------------------------------------------------------------------
module fir_mac (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  fir_pkg::mac_ctrl_t                      ctrl,
    input  logic signed [fir_pkg::SAMPLE_W-1:0]     coeff,
    input  logic signed [fir_pkg::SAMPLE_W-1:0]     sample,
    output logic                                    busy,
    output logic [fir_pkg::SAMPLE_W-1:0]            result
);
    import fir_pkg::*;

    logic                     prod_v_reg;
    logic signed [ACC_W-1:0]  prod_reg;
    logic [ACC_W-1:0]         acc_reg;

    // Product valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_v_reg <= 1'b0;
        end else begin
            prod_v_reg <= ctrl.op_valid;
        end
    end

    // Multiply stage, then accumulate stage (wraps modulo 2^64)
    always_ff @(posedge aclk) begin
        if (ctrl.op_valid) begin
            prod_reg <= coeff * sample;
        end
        if (ctrl.clear) begin
            acc_reg <= '0;
        end else if (prod_v_reg) begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    assign busy   = prod_v_reg;
    assign result = acc_reg[Q31_SHIFT +: SAMPLE_W];

endmodule

[src/fir_filter_q31.sv]
// ----------------------------------------------------------------------------
// fir_filter_q31
// Q31 direct-form FIR filter with one shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
// A sample transfer (s_tuser = 0) pushes s_tdata[31:0] into a circular delay
// line and starts T multiply-accumulate steps, T being tap_count clamped to
// 1..32; coefficient k meets the k-th oldest of the newest T samples. The
// output is bits 62..31 of the wrapping 64-bit sum, truncated, unsaturated.
// A sample runs one tap per cycle through the single multiplier, then through
// the RAM read, multiply and accumulate registers before the next possible
// transfer. A coefficient transfer (s_tuser = 1) keeps s_tready high and
// produces no output. s_tready is low while a sample is being processed;
// a finished result waits in the output register without blocking the
// next transfer. Both stores read as zero after reset.
// ----------------------------------------------------------------------------
module fir_filter_q31 (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // Configuration: tap_count
    input  logic                                 cfg_wr_en,
    input  logic [fir_pkg::TAP_COUNT_W-1:0]      cfg_wr_data,
    // Input stream
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // [31:0] sample_in, [36:32] coeff_index, [68:37] coeff_value, [71:69] zero
    input  logic [fir_pkg::S_TDATA_W-1:0]        s_tdata,
    // [0] req_type
    input  logic                                 s_tuser,
    // Output stream
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // [31:0] filtered_sample
    output logic [fir_pkg::M_TDATA_W-1:0]        m_tdata
);
    import fir_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } state_t;

    state_t                   state_reg;
    logic [TAP_COUNT_W-1:0]   tap_count_reg;
    logic [TAP_W-1:0]         wr_ptr_reg;
    logic [TAP_W-1:0]         rd_ptr_reg;
    logic [TAP_W-1:0]         k_reg;
    logic [TAP_W-1:0]         k_last_reg;
    logic                     issue_v_reg;
    logic                     dl_vq_reg;
    logic                     co_vq_reg;
    logic [MAX_TAPS-1:0]      dl_valid_reg;
    logic [MAX_TAPS-1:0]      co_valid_reg;
    logic                     m_tvalid_reg;
    logic [M_TDATA_W-1:0]     m_tdata_reg;

    logic                     in_xfer;
    logic                     smp_xfer;
    logic                     coe_xfer;
    logic                     coe_in_range;
    logic [SAMPLE_W-1:0]      sample_in;
    logic [COEFF_IDX_W-1:0]   coeff_index;
    logic [SAMPLE_W-1:0]      coeff_value;
    logic [TAP_W:0]           taps_eff;
    logic [TAP_W-1:0]         last_k;
    logic [TAP_W:0]           start_sum;
    logic [TAP_W-1:0]         start_ptr;
    logic [TAP_W-1:0]         wr_ptr_next;
    logic [TAP_W-1:0]         rd_ptr_next;
    logic [SAMPLE_W-1:0]      dl_rdata;
    logic [SAMPLE_W-1:0]      co_rdata;
    logic signed [SAMPLE_W-1:0] dl_op;
    logic signed [SAMPLE_W-1:0] co_op;
    mac_ctrl_t                mac_ctrl;
    logic                     mac_busy;
    logic [SAMPLE_W-1:0]      mac_result;
    logic                     out_free;
    logic                     drain_done;

    // Field unpacking
    assign sample_in   = s_tdata[SAMPLE_W-1:0];
    assign coeff_index = s_tdata[SAMPLE_W +: COEFF_IDX_W];
    assign coeff_value = s_tdata[SAMPLE_W+COEFF_IDX_W +: SAMPLE_W];

    assign s_tready     = (state_reg == ST_IDLE);
    assign in_xfer      = s_tvalid && s_tready;
    assign smp_xfer     = in_xfer && (s_tuser == REQ_FILTER);
    assign coe_xfer     = in_xfer && (s_tuser == REQ_COEFF);
    assign coe_in_range = (32'(coeff_index) < MAX_TAPS);
    assign out_free     = !m_tvalid_reg || m_tready;

    // Pipeline empty and output register free: hand the sum over
    assign drain_done = (state_reg == ST_DRAIN) && !issue_v_reg && !mac_busy && out_free;

    // Effective tap count, clamped to 1..MAX_TAPS
    always_comb begin
        priority if (tap_count_reg == '0) begin
            taps_eff = (TAP_W+1)'(1);
        end else if (32'(tap_count_reg) > MAX_TAPS) begin
            taps_eff = (TAP_W+1)'(MAX_TAPS);
        end else begin
            taps_eff = (TAP_W+1)'(tap_count_reg);
        end
    end
    assign last_k = TAP_W'(taps_eff - (TAP_W+1)'(1));

    // Oldest sample in use sits last_k entries behind the newest
    always_comb begin
        start_sum = {1'b0, wr_ptr_reg} + (TAP_W+1)'(MAX_TAPS) - {1'b0, last_k};
        if (32'(start_sum) >= MAX_TAPS) begin
            start_ptr = TAP_W'(start_sum - (TAP_W+1)'(MAX_TAPS));
        end else begin
            start_ptr = TAP_W'(start_sum);
        end
    end

    // Circular pointer increments
    assign wr_ptr_next = (32'(wr_ptr_reg) == MAX_TAPS - 1) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_next = (32'(rd_ptr_reg) == MAX_TAPS - 1) ? '0 : rd_ptr_reg + 1'b1;

    // Sequencer, store valid bits, config register, output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            tap_count_reg <= TAP_COUNT_RESET;
            wr_ptr_reg    <= '0;
            dl_valid_reg  <= '0;
            co_valid_reg  <= '0;
            issue_v_reg   <= 1'b0;
            m_tvalid_reg  <= 1'b0;
            m_tdata_reg   <= '0;
        end else begin
            if (cfg_wr_en) begin
                tap_count_reg <= cfg_wr_data;
            end
            if (coe_xfer && coe_in_range) begin
                co_valid_reg[TAP_W'(coeff_index)] <= 1'b1;
            end
            if (drain_done) begin
                m_tvalid_reg <= 1'b1;
                m_tdata_reg  <= mac_result;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            issue_v_reg <= (state_reg == ST_RUN);
            unique case (state_reg)
                ST_IDLE: begin
                    if (smp_xfer) begin
                        dl_valid_reg[wr_ptr_reg] <= 1'b1;
                        wr_ptr_reg               <= wr_ptr_next;
                        state_reg                <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (k_reg == k_last_reg) begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (drain_done) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Tap counters and operand valid flags
    always_ff @(posedge aclk) begin
        if (smp_xfer) begin
            rd_ptr_reg <= start_ptr;
            k_reg      <= '0;
            k_last_reg <= last_k;
        end else if (state_reg == ST_RUN) begin
            rd_ptr_reg <= rd_ptr_next;
            k_reg      <= k_reg + 1'b1;
        end
        dl_vq_reg <= dl_valid_reg[rd_ptr_reg];
        co_vq_reg <= co_valid_reg[k_reg];
    end

    // Delay line store
    fir_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_TAPS)
    ) u_delay_ram (
        .aclk  (aclk),
        .we    (smp_xfer),
        .waddr (wr_ptr_reg),
        .wdata (sample_in),
        .raddr (rd_ptr_reg),
        .rdata (dl_rdata)
    );

    // Coefficient store
    fir_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_TAPS)
    ) u_coeff_ram (
        .aclk  (aclk),
        .we    (coe_xfer && coe_in_range),
        .waddr (TAP_W'(coeff_index)),
        .wdata (coeff_value),
        .raddr (k_reg),
        .rdata (co_rdata)
    );

    // Never-written entries read as zero
    assign dl_op = dl_vq_reg ? $signed(dl_rdata) : '0;
    assign co_op = co_vq_reg ? $signed(co_rdata) : '0;

    assign mac_ctrl.clear    = smp_xfer;
    assign mac_ctrl.op_valid = issue_v_reg;

    fir_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (mac_ctrl),
        .coeff   (co_op),
        .sample  (dl_op),
        .busy    (mac_busy),
        .result  (mac_result)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

[src/fir_checker.sv]
// ----------------------------------------------------------------------------
// fir_checker
// Port-level checks for the Q31 FIR filter, bound to the top level.
// ----------------------------------------------------------------------------
module fir_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            s_tuser,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [fir_pkg::M_TDATA_W-1:0]   m_tdata
);
    import fir_pkg::*;

    // A stalled result holds its value
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output changed while stalled");

    // A sample transfer makes the block busy in the next cycle
    a_busy_after_sample: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == REQ_FILTER) |=> !s_tready)
        else $error("ready after sample transfer");

    // A coefficient write leaves the input ready in the next cycle
    a_coeff_one_cycle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == REQ_COEFF) |=> s_tready)
        else $error("not ready after coefficient transfer");

    // A new result only appears at the end of a busy period
    a_result_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result without preceding computation");

endmodule

bind fir_filter_q31 fir_checker u_fir_checker (.*);

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb: self-checking bench for fir_filter_q31
// Streams sample and coefficient transfers through the filter, predicts every
// filtered output in a local Q31 FIR model, and checks each output transfer in
// order. Tap count is changed between phases, covering its extremes.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fir_pkg::*;

    localparam int SETTLE    = 2 * MAX_TAPS + 8;   // cycles to let a sample finish
    localparam int PHASE_LEN = 100;

    typedef struct {
        logic                 kind;
        logic [S_TDATA_W-1:0] data;
    } fir_req_t;

    logic                   aclk        = 1'b0;
    logic                   aresetn     = 1'b0;
    logic                   cfg_wr_en   = 1'b0;
    logic [TAP_COUNT_W-1:0] cfg_wr_data = '0;
    logic                   s_tvalid    = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata     = '0;
    logic                   s_tuser     = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready    = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;

    // Local copy of the filter state
    logic [SAMPLE_W-1:0]    hist [MAX_TAPS];
    logic [SAMPLE_W-1:0]    coeffs [MAX_TAPS];
    logic [TAP_COUNT_W-1:0] tap_cfg;

    fir_req_t               to_send [$];
    logic [M_TDATA_W-1:0]   expected_out [$];

    int  queued = 0, fed = 0, results = 0, errors = 0;
    int  n_samples = 0, n_coeffs = 0, n_settings = 0;
    bit  calm = 1'b0;
    int  in_gap = 0, out_gap = 0;

    fir_filter_q31 uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Push one sample, return bits 62..31 of the wrapping 64-bit MAC sum
    function automatic logic [M_TDATA_W-1:0] filter_sample(input logic [SAMPLE_W-1:0] x);
        logic [ACC_W-1:0] acc;
        longint           c, d;
        int               t;
        for (int k = MAX_TAPS - 1; k > 0; k--) hist[k] = hist[k-1];
        hist[0] = x;
        // zero taps act as one, anything above the build limit as the limit
        t = (tap_cfg == 0) ? 1 : ((tap_cfg > MAX_TAPS) ? MAX_TAPS : int'(tap_cfg));
        acc = '0;
        for (int k = 0; k < t; k++) begin
            c = longint'($signed(coeffs[k]));
            d = longint'($signed(hist[t-1-k]));
            acc += c * d;
        end
        return acc[ACC_W-2:Q31_SHIFT];
    endfunction

    // Mostly random Q31 values, with the extremes showing up often
    function automatic logic [31:0] rand_q31();
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'($signed($urandom_range(0, 255)) - 128);
            default: return $urandom();
        endcase
    endfunction

    task automatic push_sample(input logic [31:0] x, input bit noisy);
        fir_req_t r;
        r.kind = REQ_FILTER;
        r.data = '0;
        r.data[31:0] = x;
        if (noisy) begin
            r.data[36:32] = 5'($urandom());
            r.data[68:37] = $urandom();
        end
        to_send.push_back(r);
        queued++;
    endtask

    task automatic push_coeff(input logic [4:0] idx, input logic [31:0] v, input bit noisy);
        fir_req_t r;
        r.kind = REQ_COEFF;
        r.data = '0;
        r.data[36:32] = idx;
        r.data[68:37] = v;
        if (noisy) r.data[31:0] = $urandom();
        to_send.push_back(r);
        queued++;
    endtask

    // Wait until every transfer is in and every output is out, then let the
    // filter settle before the next phase
    task automatic drain();
        while (fed != queued || expected_out.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_taps(input logic [TAP_COUNT_W-1:0] v);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        tap_cfg      = v;
        n_settings++;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic random_phase(input int n);
        int t;
        t = (tap_cfg == 0) ? 1 : ((tap_cfg > MAX_TAPS) ? MAX_TAPS : int'(tap_cfg));
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < 25) begin
                if ($urandom_range(0, 1) == 0)
                    push_coeff(5'($urandom_range(0, t - 1)), rand_q31(), 1'b1);
                else
                    push_coeff(5'($urandom()), rand_q31(), 1'b1);
            end else begin
                push_sample(rand_q31(), 1'b1);
            end
        end
    endtask

    // Input driver: holds each transfer until accepted, predicts on acceptance
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                fed++;
                if (s_tuser == REQ_FILTER) begin
                    expected_out.push_back(filter_sample(s_tdata[31:0]));
                    n_samples++;
                end else begin
                    coeffs[s_tdata[36:32]] = s_tdata[68:37];
                    n_coeffs++;
                end
            end
            if (!s_tvalid || s_tready) begin
                if (in_gap > 0) begin
                    in_gap--;
                    s_tvalid <= 1'b0;
                end else if (!calm && $urandom_range(0, 7) == 0) begin
                    in_gap = $urandom_range(1, 13) - 1;
                    s_tvalid <= 1'b0;
                end else if (to_send.size() != 0) begin
                    fir_req_t r;
                    r = to_send.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= r.kind;
                    s_tdata  <= r.data;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Output monitor with random back-pressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                results++;
                if (expected_out.size() == 0) begin
                    $error("filtered_sample: unexpected output transfer, actual %h", m_tdata);
                    errors++;
                end else begin
                    logic [M_TDATA_W-1:0] want;
                    want = expected_out.pop_front();
                    if (m_tdata !== want) begin
                        $error("filtered_sample: expected %h, actual %h", want, m_tdata);
                        errors++;
                    end
                end
            end
            if (out_gap > 0) begin
                out_gap--;
                m_tready <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                out_gap = $urandom_range(1, 13) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Stimulus and end of run
    initial begin
        logic [TAP_COUNT_W-1:0] tap_plan [14];
        tap_plan = '{6'd32, 6'd63, 6'd5, 6'd1, 6'd0, 6'd17, 6'd33,
                     6'd8, 6'd2, 6'd31, 6'd12, 6'd3, 6'd24, 6'd32};
        for (int k = 0; k < MAX_TAPS; k++) begin
            hist[k]   = '0;
            coeffs[k] = '0;
        end
        tap_cfg = TAP_COUNT_RESET;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset tap count, zero coefficients, then extreme products
        push_sample(32'h1234_5678, 1'b0);
        push_coeff(5'd31, 32'h7FFF_FFFF, 1'b0);
        push_coeff(5'd0,  32'h8000_0000, 1'b0);
        push_sample(32'h7FFF_FFFF, 1'b0);
        push_sample(32'h8000_0000, 1'b0);
        push_sample(32'hFFFF_FFFF, 1'b0);
        push_sample(32'h0000_0001, 1'b0);
        drain();

        // Single tap: most negative squared
        write_taps(6'd1);
        push_coeff(5'd0, 32'h8000_0000, 1'b0);
        push_sample(32'h8000_0000, 1'b0);
        push_sample(32'h7FFF_FFFF, 1'b0);
        drain();

        // Zero taps behave as one
        write_taps(6'd0);
        push_sample(32'h8000_0000, 1'b0);
        push_sample(32'h0000_0000, 1'b0);
        drain();

        // Four full-scale products wrap the accumulator
        write_taps(6'd4);
        push_coeff(5'd1, 32'h8000_0000, 1'b0);
        push_coeff(5'd2, 32'h8000_0000, 1'b0);
        push_coeff(5'd3, 32'h8000_0000, 1'b0);
        repeat (4) push_sample(32'h8000_0000, 1'b0);
        push_sample(32'h7FFF_FFFF, 1'b0);
        drain();

        // Random phases, history kept across tap count changes
        foreach (tap_plan[p]) begin
            write_taps(tap_plan[p]);
            if (p == $size(tap_plan) - 1) calm = 1'b1;
            random_phase(PHASE_LEN);
            drain();
        end

        if (expected_out.size() != 0) begin
            $error("filtered_sample: %0d outputs never arrived", expected_out.size());
            errors++;
        end
        $display("Covered %0d samples and %0d coefficient writes over %0d tap settings",
                 n_samples, n_coeffs, n_settings);
        $display("Checked %0d output transfers, %0d mismatches", results, errors);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[sim.f]
src/fir_pkg.sv
src/fir_ram.sv
src/fir_mac.sv
src/fir_filter_q31.sv
src/fir_checker.sv
test/tb.sv
